// ===== rtl/core/kced_pkg.sv =====
// Key click event detector: shared types, codes and reset values.
// No dependencies; compiled first.
package kced_pkg;

    typedef logic [31:0] tick_t;
    typedef logic [15:0] cfg_val_t;
    typedef logic [1:0]  cfg_idx_t;
    typedef logic [1:0]  click_cnt_t;

    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_PRESS_DEB     = 4'd1,
        PH_PRESS         = 4'd2,
        PH_RELEASE_DEB   = 4'd3,
        PH_RELEASE       = 4'd4,
        PH_WAIT_DOUBLE   = 4'd5,
        PH_DOUBLE        = 4'd6,
        PH_HOLD          = 4'd7,
        PH_LONG          = 4'd8,
        PH_WAIT_LONG_REL = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } key_event_t;

    localparam cfg_idx_t CFG_DEBOUNCE     = 2'd0;
    localparam cfg_idx_t CFG_DOUBLE_CLICK = 2'd1;
    localparam cfg_idx_t CFG_LONG_PRESS   = 2'd2;

    localparam cfg_val_t DEBOUNCE_RST     = 16'd20;
    localparam cfg_val_t DOUBLE_CLICK_RST = 16'd300;
    localparam cfg_val_t LONG_PRESS_RST   = 16'd1000;

    typedef struct packed {
        cfg_val_t debounce_ticks;
        cfg_val_t double_click_window;
        cfg_val_t long_press_ticks;
    } kced_cfg_t;

endpackage

// ===== rtl/core/kced_ifs.sv =====
// Key click event detector: valid/ready channel interfaces for poll input,
// event output and register writes. Depends on kced_pkg.
interface kced_in_if import kced_pkg::*;;
    logic  valid;
    logic  ready;
    tick_t tick_now;
    logic  key_pressed;

    modport source (output valid, output tick_now, output key_pressed, input ready);
    modport sink   (input valid, input tick_now, input key_pressed, output ready);
endinterface

interface kced_out_if import kced_pkg::*;;
    logic       valid;
    logic       ready;
    key_event_t key_event;

    modport source (output valid, output key_event, input ready);
    modport sink   (input valid, input key_event, output ready);
endinterface

interface kced_cfg_if import kced_pkg::*;;
    logic     valid;
    logic     ready;
    cfg_idx_t idx;
    cfg_val_t data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/core/kced_fsm.sv =====
// Key click event detector: ten-phase debounce/click state machine.
// Depends on kced_pkg. Updates state on each accepted poll.
module kced_fsm
    import kced_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  tick_t      tick_now,
    input  logic       key_pressed,
    input  kced_cfg_t  cfg,
    output key_event_t key_event
);

    phase_t     phase_reg,  phase_next;
    tick_t      edge_tick_reg,   edge_tick_next;
    click_cnt_t click_count_reg, click_count_next;
    tick_t      window_tick_reg, window_tick_next;
    tick_t      hold_tick_reg,   hold_tick_next;

    tick_t      since_edge, since_window, since_hold;
    logic       deb_done, window_over, hold_over, long_hit;
    click_cnt_t count_inc;

    // wrapping 32-bit differences
    assign since_edge   = tick_now - edge_tick_reg;
    assign since_window = tick_now - window_tick_reg;
    assign since_hold   = tick_now - hold_tick_reg;

    assign deb_done    = since_edge   >  {16'd0, cfg.debounce_ticks};
    assign window_over = since_window >  {16'd0, cfg.double_click_window};
    assign hold_over   = since_hold   >  {16'd0, cfg.double_click_window};
    assign long_hit    = since_hold   >= {16'd0, cfg.long_press_ticks};
    assign count_inc   = click_count_reg + 2'd1;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        edge_tick_next   = edge_tick_reg;
        click_count_next = click_count_reg;
        window_tick_next = window_tick_reg;
        hold_tick_next   = hold_tick_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (key_pressed)
                begin
                    edge_tick_next = tick_now;
                    phase_next     = PH_PRESS_DEB;
                end
            end
            PH_PRESS_DEB:
            begin
                if (!key_pressed)
                    phase_next = PH_IDLE;
                else if (deb_done)
                    phase_next = PH_PRESS;
            end
            PH_PRESS:
            begin
                hold_tick_next = tick_now;
                phase_next     = PH_HOLD;
            end
            PH_RELEASE_DEB:
            begin
                if (key_pressed)
                    phase_next = PH_PRESS;
                else if (deb_done)
                    phase_next = PH_RELEASE;
            end
            PH_RELEASE:
            begin
                // counts that wrap past two stay here and count again
                click_count_next = count_inc;
                if (count_inc == 2'd1)
                begin
                    window_tick_next = tick_now;
                    phase_next       = PH_WAIT_DOUBLE;
                end
                else if (count_inc == 2'd2)
                    phase_next = PH_DOUBLE;
            end
            PH_WAIT_DOUBLE:
            begin
                if (key_pressed)
                begin
                    edge_tick_next = tick_now;
                    phase_next     = PH_PRESS_DEB;
                end
                else if (window_over)
                begin
                    click_count_next = 2'd0;
                    phase_next       = PH_IDLE;
                end
            end
            PH_DOUBLE:
            begin
                window_tick_next = '0;
                click_count_next = 2'd0;
                phase_next       = PH_IDLE;
            end
            PH_HOLD:
            begin
                if (!key_pressed)
                begin
                    // late release: back to idle, count kept
                    if (hold_over)
                        phase_next = PH_IDLE;
                    else
                    begin
                        edge_tick_next = tick_now;
                        phase_next     = PH_RELEASE_DEB;
                    end
                end
                else if (long_hit)
                begin
                    hold_tick_next = '0;
                    phase_next     = PH_LONG;
                end
            end
            PH_LONG:
                phase_next = PH_WAIT_LONG_REL;
            PH_WAIT_LONG_REL:
            begin
                if (!key_pressed)
                begin
                    click_count_next = 2'd0;
                    phase_next       = PH_IDLE;
                end
            end
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // event output
    always_comb
    begin
        key_event = EV_NONE;
        unique case (phase_reg)
            PH_WAIT_DOUBLE:
                if (!key_pressed && window_over)
                    key_event = EV_SINGLE;
            PH_DOUBLE:
                key_event = EV_DOUBLE;
            PH_LONG:
                key_event = EV_LONG;
            default:
                key_event = EV_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            edge_tick_reg   <= '0;
            click_count_reg <= 2'd0;
            window_tick_reg <= '0;
            hold_tick_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            edge_tick_reg   <= edge_tick_next;
            click_count_reg <= click_count_next;
            window_tick_reg <= window_tick_next;
            hold_tick_reg   <= hold_tick_next;
        end
    end

    a_press_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PRESS |=> phase_reg == PH_HOLD)
        else $error("press phase did not move to hold");

    a_double_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_DOUBLE |=> phase_reg == PH_IDLE && click_count_reg == 2'd0)
        else $error("double click did not clear the sequence");

    a_long_zeroes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_HOLD && phase_next == PH_LONG |=> hold_tick_reg == '0)
        else $error("long press left hold start set");

    a_single_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
        key_event == EV_SINGLE |-> phase_reg == PH_WAIT_DOUBLE && phase_next == PH_IDLE)
        else $error("single click outside the double-click wait");

endmodule

// ===== rtl/core/key_click_event_detector_top.sv =====
// An accepted poll's event is registered; its beat shows on out_ch next cycle.
// One poll per cycle unless out_ch stalls; the phase machine updates on the
// accept edge. The output register frees in the same cycle its beat is taken.
// Reset (rst_n low, async): phase idle, ticks and count zero, registers at
// debounce 20, double-click window 300, long press 1000; no beat pending.
// Top level of the key click event detector. Depends on kced_pkg, kced_ifs
// and kced_fsm.
module key_click_event_detector_top
    import kced_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kced_in_if.sink     in_ch,
    kced_out_if.source  out_ch,
    kced_cfg_if.sink    cfg_ch
);

    kced_cfg_t  cfg_reg;
    logic       out_valid_reg;
    key_event_t out_event_reg;
    key_event_t step_event;
    logic       in_beat;
    logic       cfg_beat;

    // A new poll is taken whenever the result slot is empty or is being
    // drained this cycle, so polls stream at one per clock under no stall.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_beat     = in_ch.valid && in_ch.ready;

    // Writes land at once; the user must issue them only while idle, unchecked.
    assign cfg_ch.ready = 1'b1;
    assign cfg_beat     = cfg_ch.valid;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.key_event = out_event_reg;

    kced_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_beat),
        .tick_now    (in_ch.tick_now),
        .key_pressed (in_ch.key_pressed),
        .cfg         (cfg_reg),
        .key_event   (step_event)
    );

    // Configuration registers; index three is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks      <= DEBOUNCE_RST;
            cfg_reg.double_click_window <= DOUBLE_CLICK_RST;
            cfg_reg.long_press_ticks    <= LONG_PRESS_RST;
        end
        else if (cfg_beat)
        begin
            unique case (cfg_ch.idx)
                CFG_DEBOUNCE:     cfg_reg.debounce_ticks      <= cfg_ch.data;
                CFG_DOUBLE_CLICK: cfg_reg.double_click_window <= cfg_ch.data;
                CFG_LONG_PRESS:   cfg_reg.long_press_ticks    <= cfg_ch.data;
                default:          ;
            endcase
        end
    end

    // Result register: every poll yields exactly one event beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_beat)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            out_event_reg <= step_event;
    end

    a_beat_follows_poll: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> out_valid_reg && out_event_reg == $past(step_event))
        else $error("accepted poll produced no event beat");

    a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !in_beat && (!out_valid_reg || out_ch.ready) |=> !out_valid_reg)
        else $error("event beat without a poll");

    a_cfg_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_beat && cfg_ch.idx == CFG_DEBOUNCE |=>
            cfg_reg.debounce_ticks == $past(cfg_ch.data))
        else $error("debounce register write lost");

endmodule
